// ===== hdl/rwu_pkg.sv =====
// ----------------------------------------------------------------------------
// rwu_pkg: shared types and constants for the rprop weight update core
// Field widths, operation and sign codes, register indexes and the
// structures that travel between the front end, queue and back end.
// ----------------------------------------------------------------------------
package rwu_pkg;

  // field widths
  localparam int unsigned IndexWidth    = 10;
  localparam int unsigned WeightWidth   = 32;
  localparam int unsigned StepWidth     = 31;
  localparam int unsigned FactorWidth   = 16;
  localparam int unsigned FactorFrac    = 12;
  localparam int unsigned SignWidth     = 2;
  localparam int unsigned ProdWidth     = StepWidth + FactorWidth;
  localparam int unsigned ScaledWidth   = ProdWidth - FactorFrac;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned RamWidth      = WeightWidth + StepWidth + SignWidth;

  // register defaults
  localparam logic [FactorWidth-1:0] IncreaseReset = 16'd4506;
  localparam logic [FactorWidth-1:0] DecreaseReset = 16'd2048;
  localparam logic [StepWidth-1:0]   StepMaxReset  = 31'd3276800;
  localparam logic [StepWidth-1:0]   StepMinReset  = 31'd1;
  localparam logic [StepWidth-1:0]   InitStepReset = 31'd6554;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_HOLD   = 2'd1,
    OP_ZERO   = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  typedef enum logic [SignWidth-1:0] {
    SIGN_ZERO = 2'b00,
    SIGN_POS  = 2'b01,
    SIGN_NEG  = 2'b11
  } sign_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_INCREASE = 3'd0,
    CFG_DECREASE = 3'd1,
    CFG_STEP_MAX = 3'd2,
    CFG_STEP_MIN = 3'd3,
    CFG_INIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [FactorWidth-1:0] increase_factor;
    logic [FactorWidth-1:0] decrease_factor;
    logic [StepWidth-1:0]   step_max;
    logic [StepWidth-1:0]   step_min;
    logic [StepWidth-1:0]   initial_step;
  } cfg_t;

  // one classified word as it waits in the queue
  typedef struct packed {
    op_e                      op;
    sign_e                    grad_sign;
    logic [IndexWidth-1:0]    entry_index;
    logic signed [WeightWidth-1:0] load_value;
  } item_t;

endpackage

// ===== hdl/rwu_ram.sv =====
// ----------------------------------------------------------------------------
// rwu_ram: generic single write, single read ram
// One write port and one read port, read data registered, read-old on a
// clash of addresses. No reset of the contents.
// ----------------------------------------------------------------------------
module rwu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rwu_front.sv =====
// ----------------------------------------------------------------------------
// rwu_front: command decode and classification
// Folds the entry index onto the store depth, classifies the gradient sign
// and packs the word that is pushed into the queue.
// ----------------------------------------------------------------------------
module rwu_front #(
  parameter int unsigned ENTRY_DEPTH = 1024,
  localparam int unsigned AddrWidth = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1
) (
  input  logic [1:0]                          op_i,
  input  logic [rwu_pkg::IndexWidth-1:0]      entry_index_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] gradient_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] load_value_i,
  output logic [AddrWidth-1:0]                addr_o,
  output rwu_pkg::item_t                      item_o
);

  localparam int unsigned IdxW = rwu_pkg::IndexWidth;

  logic [IdxW-1:0] rem;

  // index modulo depth by restoring subtraction of shifted depths
  always_comb begin
    rem = entry_index_i;
    for (int k = IdxW - 1; k >= 0; k--) begin
      if (longint'(rem) >= (longint'(ENTRY_DEPTH) << k)) begin
        rem = rem - IdxW'(longint'(ENTRY_DEPTH) << k);
      end
    end
  end

  assign addr_o = AddrWidth'(rem);

  // gradient sign class and word packing
  always_comb begin
    item_o.op          = rwu_pkg::op_e'(op_i);
    item_o.entry_index = entry_index_i;
    item_o.load_value  = load_value_i;
    if (gradient_i == '0) begin
      item_o.grad_sign = rwu_pkg::SIGN_ZERO;
    end else if (gradient_i[rwu_pkg::WeightWidth-1]) begin
      item_o.grad_sign = rwu_pkg::SIGN_NEG;
    end else begin
      item_o.grad_sign = rwu_pkg::SIGN_POS;
    end
  end

endmodule

// ===== hdl/rwu_queue.sv =====
// ----------------------------------------------------------------------------
// rwu_queue: two-word queue between front end and back end
// Register based, head word readable in the cycle it is popped.
// ----------------------------------------------------------------------------
module rwu_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");
`endif

endmodule

// ===== hdl/rwu_back.sv =====
// ----------------------------------------------------------------------------
// rwu_back: entry store and update pipeline
// Read stage, step adaptation stage (multiply and clamp) and weight stage
// (saturating add and write back), with forwarding of entries still in
// flight so that the same entry may follow in the next cycle.
// ----------------------------------------------------------------------------
module rwu_back #(
  parameter int unsigned ENTRY_DEPTH = 1024,
  localparam int unsigned AddrWidth = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rwu_pkg::cfg_t                         cfg_i,
  input  logic                                  item_valid_i,
  input  logic [AddrWidth-1:0]                  item_addr_i,
  input  rwu_pkg::item_t                        item_i,
  output logic                                  adapt_busy_o,
  output logic                                  res_valid_o,
  output logic [rwu_pkg::IndexWidth-1:0]        res_index_o,
  output logic signed [rwu_pkg::WeightWidth-1:0] res_weight_o,
  output logic [rwu_pkg::StepWidth-1:0]         res_step_o,
  output logic                                  res_sat_o
);

  localparam int unsigned WW = rwu_pkg::WeightWidth;
  localparam int unsigned SW = rwu_pkg::StepWidth;
  localparam int unsigned FW = rwu_pkg::FactorWidth;
  localparam int unsigned PW = rwu_pkg::ProdWidth;
  localparam int unsigned QW = rwu_pkg::ScaledWidth;
  localparam int unsigned GW = rwu_pkg::SignWidth;
  localparam int unsigned RW = rwu_pkg::RamWidth;

  // entry store
  logic                 ram_we;
  logic [AddrWidth-1:0] ram_waddr;
  logic [RW-1:0]        ram_wdata;
  logic [RW-1:0]        ram_rdata;

  rwu_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (item_valid_i),
    .raddr_i(item_addr_i),
    .rdata_o(ram_rdata)
  );

  // stage 1 registers
  logic                 s1_valid_q;
  logic [AddrWidth-1:0] s1_addr_q;
  rwu_pkg::item_t       s1_item_q;

  // stage 2 registers
  logic                 s2_valid_q, s2_valid_d;
  logic [AddrWidth-1:0] s2_addr_q;
  logic [rwu_pkg::IndexWidth-1:0] s2_index_q;
  logic                 s2_update_q, s2_update_d;
  logic                 s2_keep_q, s2_keep_d;
  logic signed [WW-1:0] s2_weight_q, s2_weight_d;
  logic [SW-1:0]        s2_step_q, s2_step_d;
  logic [GW-1:0]        s2_sign_q, s2_sign_d;

  // retired word, also the result register
  logic                 w_valid_q;
  logic [AddrWidth-1:0] w_addr_q;
  logic [rwu_pkg::IndexWidth-1:0] w_index_q;
  logic signed [WW-1:0] w_weight_q;
  logic [SW-1:0]        w_step_q;
  logic [GW-1:0]        w_sign_q;
  logic                 w_sat_q;

  // stage 1 working signals
  logic signed [WW-1:0] ram_weight;
  logic [SW-1:0]        ram_step;
  logic [GW-1:0]        ram_sign;
  logic signed [WW-1:0] cur_weight;
  logic [SW-1:0]        cur_step;
  logic [GW-1:0]        cur_sign;
  logic                 signs_agree;
  logic                 adapt;
  logic [FW-1:0]        factor;
  logic [PW-1:0]        product;
  logic [QW-1:0]        scaled;
  logic [SW-1:0]        grown_step;
  logic [SW-1:0]        shrunk_step;
  logic [SW-1:0]        adapted_step;

  // stage 2 working signals
  logic signed [WW-1:0] old_weight;
  logic signed [WW:0]   ext_weight;
  logic signed [WW:0]   ext_step;
  logic signed [WW:0]   sum;
  logic signed [WW-1:0] new_weight;
  logic                 sat;

  assign {ram_weight, ram_step, ram_sign} = ram_rdata;

  // read stage: capture the popped word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_addr_q <= item_addr_i;
      s1_item_q <= item_i;
    end
  end

  // the adaptation stage is the only reader of the registers
  assign adapt_busy_o = s1_valid_q;

  // forwarding of step and sign from the words ahead, newest first
  always_comb begin
    if (s2_valid_q && (s2_addr_q == s1_addr_q)) begin
      cur_step = s2_step_q;
      cur_sign = s2_sign_q;
    end else if (w_valid_q && (w_addr_q == s1_addr_q)) begin
      cur_step = w_step_q;
      cur_sign = w_sign_q;
    end else begin
      cur_step = ram_step;
      cur_sign = ram_sign;
    end
    // the word in stage 2 is caught up there on the next cycle
    if (w_valid_q && (w_addr_q == s1_addr_q)) begin
      cur_weight = w_weight_q;
    end else begin
      cur_weight = ram_weight;
    end
  end

  // step adaptation: one multiply, then a clamp to the maximum or to the minimum
  always_comb begin
    signs_agree = (s1_item_q.grad_sign == cur_sign);
    adapt       = (s1_item_q.grad_sign != rwu_pkg::SIGN_ZERO) &&
                  (cur_sign != rwu_pkg::SIGN_ZERO);
    factor      = signs_agree ? cfg_i.increase_factor : cfg_i.decrease_factor;
    product     = PW'(cur_step) * PW'(factor);
    scaled      = product[PW-1:rwu_pkg::FactorFrac];
    if (scaled < QW'(cfg_i.step_max)) begin
      grown_step = scaled[SW-1:0];
    end else begin
      grown_step = cfg_i.step_max;
    end
    if (scaled > QW'(cfg_i.step_min)) begin
      shrunk_step = (|scaled[QW-1:SW]) ? {SW{1'b1}} : scaled[SW-1:0];
    end else begin
      shrunk_step = cfg_i.step_min;
    end
    if (!adapt) begin
      adapted_step = cur_step;
    end else if (signs_agree) begin
      adapted_step = grown_step;
    end else begin
      adapted_step = shrunk_step;
    end
  end

  // per operation next state of the entry
  always_comb begin
    s2_valid_d  = s1_valid_q;
    s2_update_d = 1'b0;
    s2_keep_d   = 1'b1;
    s2_weight_d = cur_weight;
    s2_step_d   = cur_step;
    s2_sign_d   = cur_sign;
    case (s1_item_q.op)
      rwu_pkg::OP_UPDATE: begin
        s2_update_d = 1'b1;
        s2_step_d   = adapted_step;
        s2_sign_d   = s1_item_q.grad_sign;
      end
      rwu_pkg::OP_HOLD: begin
        s2_keep_d = 1'b1;
      end
      rwu_pkg::OP_ZERO: begin
        s2_keep_d   = 1'b0;
        s2_weight_d = '0;
      end
      rwu_pkg::OP_LOAD: begin
        s2_keep_d   = 1'b0;
        s2_weight_d = s1_item_q.load_value;
        s2_step_d   = cfg_i.initial_step;
        s2_sign_d   = rwu_pkg::SIGN_ZERO;
      end
      default: begin
        s2_keep_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_addr_q   <= s1_addr_q;
      s2_index_q  <= s1_item_q.entry_index;
      s2_update_q <= s2_update_d;
      s2_keep_q   <= s2_keep_d;
      s2_weight_q <= s2_weight_d;
      s2_step_q   <= s2_step_d;
      s2_sign_q   <= s2_sign_d;
    end
  end

  // weight stage: catch up the word retired last cycle, saturating add
  always_comb begin
    if (s2_keep_q && w_valid_q && (w_addr_q == s2_addr_q)) begin
      old_weight = w_weight_q;
    end else begin
      old_weight = s2_weight_q;
    end
    ext_weight = (WW + 1)'(old_weight);
    ext_step   = $signed({{(WW + 1 - SW){1'b0}}, s2_step_q});
    if (s2_update_q && (s2_sign_q == rwu_pkg::SIGN_POS)) begin
      sum = ext_weight + ext_step;
    end else if (s2_update_q && (s2_sign_q == rwu_pkg::SIGN_NEG)) begin
      sum = ext_weight - ext_step;
    end else begin
      sum = ext_weight;
    end
    sat = (sum[WW] != sum[WW-1]);
    if (!sat) begin
      new_weight = sum[WW-1:0];
    end else if (sum[WW]) begin
      new_weight = {1'b1, {(WW - 1){1'b0}}};
    end else begin
      new_weight = {1'b0, {(WW - 1){1'b1}}};
    end
  end

  // write back
  assign ram_we    = s2_valid_q;
  assign ram_waddr = s2_addr_q;
  assign ram_wdata = {new_weight, s2_step_q, s2_sign_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
    end else begin
      w_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      w_addr_q   <= s2_addr_q;
      w_index_q  <= s2_index_q;
      w_weight_q <= new_weight;
      w_step_q   <= s2_step_q;
      w_sign_q   <= s2_sign_q;
      w_sat_q    <= sat;
    end
  end

  assign res_valid_o  = w_valid_q;
  assign res_index_o  = w_index_q;
  assign res_weight_o = w_weight_q;
  assign res_step_o   = w_step_q;
  assign res_sat_o    = w_sat_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_valid_q && w_sat_q) |-> (w_step_q != '0))
    else $error("weight clipped although the step was zero");
`endif

endmodule

// ===== hdl/rprop_weight_update_core.sv =====
// ----------------------------------------------------------------------------
// rprop_weight_update_core: resilient backpropagation weight update engine
// A taken command passes the queue, then the read, adapt and weight stages.
// Throughput: one command per cycle, also on the same entry back to back;
// the step multiply and clamp loop through stage 2, closed by forwarding.
// Reset (rst_ni low, asynchronous) clears the pipeline and restores the
// register defaults; the entry store is not cleared, load before use.
// Results cannot be held off by the receiver; busy stays low in operation.
// ----------------------------------------------------------------------------
module rprop_weight_update_core #(
  parameter int unsigned ENTRY_DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             op_i,
  input  logic [rwu_pkg::IndexWidth-1:0]         entry_index_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] gradient_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] load_value_i,
  // result channel
  output logic                                   strobe,
  output logic [rwu_pkg::IndexWidth-1:0]         out_index_o,
  output logic signed [rwu_pkg::WeightWidth-1:0] new_weight_o,
  output logic [rwu_pkg::StepWidth-1:0]          new_step_o,
  output logic                                   saturated_o,
  // register write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rwu_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [rwu_pkg::CfgDataWidth-1:0]       cfg_data_i
);

  localparam int unsigned AddrWidth = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int unsigned QueueWidth = AddrWidth + $bits(rwu_pkg::item_t);

  rwu_pkg::cfg_t cfg_q, cfg_d;

  logic                  accept;
  logic                  q_full;
  logic                  q_valid;
  logic                  adapt_busy;
  logic [AddrWidth-1:0]  front_addr;
  rwu_pkg::item_t        front_item;
  logic [QueueWidth-1:0] q_data;
  logic [AddrWidth-1:0]  back_addr;
  rwu_pkg::item_t        back_item;

  // register file, written only while no word is waiting to read it
  assign cfg_ready_o = !q_valid && !adapt_busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rwu_pkg::CFG_INCREASE: cfg_d.increase_factor = cfg_data_i[rwu_pkg::FactorWidth-1:0];
        rwu_pkg::CFG_DECREASE: cfg_d.decrease_factor = cfg_data_i[rwu_pkg::FactorWidth-1:0];
        rwu_pkg::CFG_STEP_MAX: cfg_d.step_max        = cfg_data_i[rwu_pkg::StepWidth-1:0];
        rwu_pkg::CFG_STEP_MIN: cfg_d.step_min        = cfg_data_i[rwu_pkg::StepWidth-1:0];
        rwu_pkg::CFG_INIT:     cfg_d.initial_step    = cfg_data_i[rwu_pkg::StepWidth-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.increase_factor <= rwu_pkg::IncreaseReset;
      cfg_q.decrease_factor <= rwu_pkg::DecreaseReset;
      cfg_q.step_max        <= rwu_pkg::StepMaxReset;
      cfg_q.step_min        <= rwu_pkg::StepMinReset;
      cfg_q.initial_step    <= rwu_pkg::InitStepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: decode and classify
  rwu_front #(
    .ENTRY_DEPTH(ENTRY_DEPTH)
  ) u_front (
    .op_i         (op_i),
    .entry_index_i(entry_index_i),
    .gradient_i   (gradient_i),
    .load_value_i (load_value_i),
    .addr_o       (front_addr),
    .item_o       (front_item)
  );

  assign busy   = q_full;
  assign accept = start && !busy;

  // queue between the two halves, drained every cycle by the back end
  rwu_queue #(
    .WIDTH(QueueWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i ({front_addr, front_item}),
    .pop_i  (q_valid),
    .valid_o(q_valid),
    .full_o (q_full),
    .data_o (q_data)
  );

  assign {back_addr, back_item} = q_data;

  // back end: store, adapt and write back
  rwu_back #(
    .ENTRY_DEPTH(ENTRY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(q_valid),
    .item_addr_i (back_addr),
    .item_i      (back_item),
    .adapt_busy_o(adapt_busy),
    .res_valid_o (strobe),
    .res_index_o (out_index_o),
    .res_weight_o(new_weight_o),
    .res_step_o  (new_step_o),
    .res_sat_o   (saturated_o)
  );

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##4 strobe)
    else $error("result word missing four cycles after a command");
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe |-> $past(accept, 4))
    else $error("result word without a command four cycles earlier");
`endif

endmodule

// ===== sim/rwu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rwu_checker: result predictor and scoreboard for the rprop update core
// Watches the command, result and register write channels of the core.
// Each taken command is run through a local model of the entry store. The
// outcome is queued, and every strobed result word is compared field by
// field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module rwu_checker #(
  parameter int unsigned EntryDepth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command channel
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic [1:0]                             op_i,
  input  logic [rwu_pkg::IndexWidth-1:0]         entry_index_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] gradient_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] load_value_i,
  // result channel
  input  logic                                   strobe_i,
  input  logic [rwu_pkg::IndexWidth-1:0]         out_index_i,
  input  logic signed [rwu_pkg::WeightWidth-1:0] new_weight_i,
  input  logic [rwu_pkg::StepWidth-1:0]          new_step_i,
  input  logic                                   saturated_i,
  // register write channel
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_ready_i,
  input  logic [rwu_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [rwu_pkg::CfgDataWidth-1:0]       cfg_data_i,
  // status towards the stimulus side
  output int unsigned                            fail_count_o,
  output int unsigned                            pending_o
);

  localparam int unsigned IndexWidth  = rwu_pkg::IndexWidth;
  localparam int unsigned WeightWidth = rwu_pkg::WeightWidth;
  localparam int unsigned StepWidth   = rwu_pkg::StepWidth;
  localparam int unsigned FactorWidth = rwu_pkg::FactorWidth;
  localparam int unsigned FactorFrac  = rwu_pkg::FactorFrac;
  localparam int unsigned ProdWidth   = rwu_pkg::ProdWidth;
  localparam int unsigned ScaledWidth = rwu_pkg::ScaledWidth;

  localparam longint WeightMax = 64'sd2147483647;
  localparam longint WeightMin = -64'sd2147483648;
  localparam logic [ScaledWidth-1:0] StepCeiling = ScaledWidth'(31'h7FFF_FFFF);

  typedef struct {
    logic [IndexWidth-1:0]  index;
    logic [WeightWidth-1:0] weight;
    logic [StepWidth-1:0]   step;
    logic                   sat;
  } entry_word_t;

  // local copy of the registers and the entry store
  logic [FactorWidth-1:0] increase_factor;
  logic [FactorWidth-1:0] decrease_factor;
  logic [StepWidth-1:0]   step_max;
  logic [StepWidth-1:0]   step_min;
  logic [StepWidth-1:0]   initial_step;

  logic [WeightWidth-1:0] weight_mem [EntryDepth];
  logic [StepWidth-1:0]   step_mem   [EntryDepth];
  rwu_pkg::sign_e         sign_mem   [EntryDepth];

  entry_word_t            expected_words [$];
  entry_word_t            oldest;
  int unsigned            fail_count;

  // scale a step by a Q4.12 factor, truncating the fraction
  function automatic logic [ScaledWidth-1:0] scale_step(logic [StepWidth-1:0] step,
                                                        logic [FactorWidth-1:0] factor);
    logic [ProdWidth-1:0] prod;
    prod = ProdWidth'(step) * ProdWidth'(factor);
    return prod[ProdWidth-1:FactorFrac];
  endfunction

  // apply one command to the local store and return the entry afterwards
  function automatic entry_word_t apply_command(rwu_pkg::op_e op,
                                                logic [IndexWidth-1:0] index,
                                                logic [WeightWidth-1:0] grad,
                                                logic [WeightWidth-1:0] load_value);
    int unsigned             e;
    rwu_pkg::sign_e          grad_sign;
    logic [StepWidth-1:0]    step;
    logic [ScaledWidth-1:0]  scaled;
    longint                  w;
    longint                  step_l;
    entry_word_t             word;
    e        = index % EntryDepth;
    word.sat = 1'b0;
    case (op)
      rwu_pkg::OP_UPDATE: begin
        if (grad == '0) grad_sign = rwu_pkg::SIGN_ZERO;
        else if (grad[WeightWidth-1]) grad_sign = rwu_pkg::SIGN_NEG;
        else grad_sign = rwu_pkg::SIGN_POS;
        step = step_mem[e];
        // step adapts only when both signs are known
        if (grad_sign != rwu_pkg::SIGN_ZERO && sign_mem[e] != rwu_pkg::SIGN_ZERO) begin
          if (grad_sign == sign_mem[e]) begin
            scaled = scale_step(step, increase_factor);
            if (scaled > ScaledWidth'(step_max)) scaled = ScaledWidth'(step_max);
          end else begin
            scaled = scale_step(step, decrease_factor);
            if (scaled < ScaledWidth'(step_min)) scaled = ScaledWidth'(step_min);
          end
          if (scaled > StepCeiling) scaled = StepCeiling;
          step = scaled[StepWidth-1:0];
        end
        // saturating move of the weight
        w      = longint'($signed(weight_mem[e]));
        step_l = longint'({1'b0, step});
        if (grad_sign == rwu_pkg::SIGN_POS) w = w + step_l;
        else if (grad_sign == rwu_pkg::SIGN_NEG) w = w - step_l;
        if (w > WeightMax) begin
          w        = WeightMax;
          word.sat = 1'b1;
        end else if (w < WeightMin) begin
          w        = WeightMin;
          word.sat = 1'b1;
        end
        weight_mem[e] = w[WeightWidth-1:0];
        step_mem[e]   = step;
        sign_mem[e]   = grad_sign;
      end
      rwu_pkg::OP_ZERO: weight_mem[e] = '0;
      rwu_pkg::OP_LOAD: begin
        weight_mem[e] = load_value;
        step_mem[e]   = initial_step;
        sign_mem[e]   = rwu_pkg::SIGN_ZERO;
      end
      default: ;
    endcase
    word.index  = index;
    word.weight = weight_mem[e];
    word.step   = step_mem[e];
    return word;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, exp_v, act_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < EntryDepth; i++) begin
      weight_mem[i] = '0;
      step_mem[i]   = '0;
      sign_mem[i]   = rwu_pkg::SIGN_ZERO;
    end
  end

  // register writes, command prediction and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      increase_factor = rwu_pkg::IncreaseReset;
      decrease_factor = rwu_pkg::DecreaseReset;
      step_max        = rwu_pkg::StepMaxReset;
      step_min        = rwu_pkg::StepMinReset;
      initial_step    = rwu_pkg::InitStepReset;
      expected_words.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (rwu_pkg::cfg_reg_e'(cfg_index_i))
          rwu_pkg::CFG_INCREASE: increase_factor = cfg_data_i[FactorWidth-1:0];
          rwu_pkg::CFG_DECREASE: decrease_factor = cfg_data_i[FactorWidth-1:0];
          rwu_pkg::CFG_STEP_MAX: step_max        = cfg_data_i[StepWidth-1:0];
          rwu_pkg::CFG_STEP_MIN: step_min        = cfg_data_i[StepWidth-1:0];
          rwu_pkg::CFG_INIT:     initial_step    = cfg_data_i[StepWidth-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_words.push_back(apply_command(rwu_pkg::op_e'(op_i), entry_index_i,
                                               gradient_i, load_value_i));
      if (strobe_i) begin
        if (expected_words.size() == 0) begin
          $error("result word for entry %0d with nothing expected", out_index_i);
          fail_count++;
        end else begin
          oldest = expected_words.pop_front();
          if (out_index_i !== oldest.index)
            note_mismatch("out_index", 32'(oldest.index), 32'(out_index_i));
          if (new_weight_i !== oldest.weight)
            note_mismatch("new_weight", oldest.weight, new_weight_i);
          if (new_step_i !== oldest.step)
            note_mismatch("new_step", 32'(oldest.step), 32'(new_step_i));
          if (saturated_i !== oldest.sat)
            note_mismatch("saturated", 32'(oldest.sat), 32'(saturated_i));
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_words.size();
  end

endmodule

// ===== sim/tb_rprop_weight_update_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rprop_weight_update_core: command stimulus for the rprop update core
// A directed set covers load extremes, sign agreement and reversal, zero
// gradients, saturation both ways, hold and zero. Six register settings
// follow, each with random commands sent in bursts with random gaps; a
// small hot set of entries builds up sign history. Checking is done by
// the checker instance, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rprop_weight_update_core;

  localparam int unsigned IndexWidth    = rwu_pkg::IndexWidth;
  localparam int unsigned WeightWidth   = rwu_pkg::WeightWidth;
  localparam int unsigned StepWidth     = rwu_pkg::StepWidth;
  localparam int unsigned CfgIndexWidth = rwu_pkg::CfgIndexWidth;
  localparam int unsigned CfgDataWidth  = rwu_pkg::CfgDataWidth;

  localparam int unsigned Depth         = 1024;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned PhaseItems    = 192;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned CycleLimit    = 400000;
  localparam logic [31:0] Mask31        = 32'h7FFF_FFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             op;
  logic [IndexWidth-1:0]  entry_index;
  logic [WeightWidth-1:0] gradient;
  logic [WeightWidth-1:0] load_value;
  logic                   strobe;
  logic [IndexWidth-1:0]  out_index;
  logic [WeightWidth-1:0] new_weight;
  logic [StepWidth-1:0]   new_step;
  logic                   saturated;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  int unsigned            fail_count;
  int unsigned            pending;
  int unsigned            cycle_count = 0;

  bit                     loaded   [Depth];
  bit                     last_neg [Depth];
  logic [IndexWidth-1:0]  hot_set  [8];
  int unsigned            burst_left;

  rprop_weight_update_core #(.ENTRY_DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op),
    .entry_index_i (entry_index),
    .gradient_i    (gradient),
    .load_value_i  (load_value),
    .strobe        (strobe),
    .out_index_o   (out_index),
    .new_weight_o  (new_weight),
    .new_step_o    (new_step),
    .saturated_o   (saturated),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  rwu_checker #(.EntryDepth(Depth)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op),
    .entry_index_i (entry_index),
    .gradient_i    (gradient),
    .load_value_i  (load_value),
    .strobe_i      (strobe),
    .out_index_i   (out_index),
    .new_weight_i  (new_weight),
    .new_step_i    (new_step),
    .saturated_i   (saturated),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // present one command word and hold it until taken
  task automatic send_command(input rwu_pkg::op_e cmd, input logic [IndexWidth-1:0] index,
                              input logic [WeightWidth-1:0] grad,
                              input logic [WeightWidth-1:0] value);
    @(negedge clk_i);
    start       <= 1'b1;
    op          <= cmd;
    entry_index <= index;
    gradient    <= grad;
    load_value  <= value;
    do @(posedge clk_i); while (busy);
    if (cmd == rwu_pkg::OP_LOAD) loaded[index] = 1'b1;
  endtask

  // drop start for a number of cycles
  task automatic idle_gap(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // wait for every expected word, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input rwu_pkg::cfg_reg_e reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // register setting of one phase, extremes and crossed limits among them
  task automatic apply_setting(input int unsigned phase);
    logic [31:0] inc_v, dec_v, max_v, min_v, init_v;
    case (phase)
      0: begin
        inc_v = 32'hFFFF; dec_v = 32'hFFFF; max_v = Mask31; min_v = 0; init_v = Mask31;
      end
      1: begin
        inc_v = 0; dec_v = 0; max_v = 0; min_v = 0; init_v = 0;
      end
      2: begin
        inc_v = 8192; dec_v = 1024; max_v = 100; min_v = 5000; init_v = 3000;
      end
      3: begin
        inc_v  = $urandom_range(0, 65535);
        dec_v  = $urandom_range(0, 65535);
        max_v  = $urandom() & Mask31;
        min_v  = $urandom_range(0, 1000);
        init_v = $urandom_range(0, 1 << 20);
      end
      4: begin
        inc_v = 6000; dec_v = 1500; max_v = 1 << 20; min_v = 16; init_v = 65536;
      end
      default: begin
        inc_v  = 32'(rwu_pkg::IncreaseReset);
        dec_v  = 32'(rwu_pkg::DecreaseReset);
        max_v  = 32'(rwu_pkg::StepMaxReset);
        min_v  = 32'(rwu_pkg::StepMinReset);
        init_v = 32'(rwu_pkg::InitStepReset);
      end
    endcase
    write_register(rwu_pkg::CFG_INCREASE, inc_v);
    write_register(rwu_pkg::CFG_DECREASE, dec_v);
    write_register(rwu_pkg::CFG_STEP_MAX, max_v);
    write_register(rwu_pkg::CFG_STEP_MIN, min_v);
    write_register(rwu_pkg::CFG_INIT, init_v);
    foreach (hot_set[i]) hot_set[i] = $urandom_range(0, Depth - 1);
  endtask

  // one random command, mostly updates on a hot entry with a sign trend
  task automatic send_random_command();
    logic [IndexWidth-1:0]  index;
    logic [WeightWidth-1:0] grad;
    logic [WeightWidth-1:0] value;
    logic [WeightWidth-1:0] mag;
    rwu_pkg::op_e           cmd;
    int unsigned            pick;
    bit                     neg;
    if ($urandom_range(0, 99) < 85) index = hot_set[$urandom_range(0, 7)];
    else index = $urandom_range(0, Depth - 1);
    pick = $urandom_range(0, 99);
    // never touch an entry before it holds a loaded value
    if (!loaded[index] || pick < 12) cmd = rwu_pkg::OP_LOAD;
    else if (pick < 70) cmd = rwu_pkg::OP_UPDATE;
    else if (pick < 85) cmd = rwu_pkg::OP_HOLD;
    else cmd = rwu_pkg::OP_ZERO;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      grad = '0;
    end else if (pick < 14) begin
      grad = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else begin
      neg = ($urandom_range(0, 99) < 70) ? last_neg[index] : !last_neg[index];
      last_neg[index] = neg;
      mag = ($urandom() & Mask31) >> $urandom_range(0, 30);
      if (mag == '0) mag = 1;
      grad = neg ? -mag : mag;
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) value = 32'h7FFF_FFFF - $urandom_range(0, 4095);
    else if (pick < 40) value = 32'h8000_0000 + $urandom_range(0, 4095);
    else value = $urandom();
    send_command(cmd, index, grad, value);
  endtask

  initial begin
    start       = 1'b0;
    op          = rwu_pkg::OP_HOLD;
    entry_index = '0;
    gradient    = '0;
    load_value  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = rwu_pkg::CFG_INCREASE;
    cfg_data    = '0;
    rst_ni      = 1'b0;
    burst_left  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words under reset register values
    send_command(rwu_pkg::OP_LOAD,   10'd0,    32'h0,         32'h7FFF_FFF0);
    send_command(rwu_pkg::OP_LOAD,   10'd1023, 32'h0,         32'h8000_0010);
    send_command(rwu_pkg::OP_LOAD,   10'd5,    32'h0,         32'h0);
    send_command(rwu_pkg::OP_LOAD,   10'd9,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_command(rwu_pkg::OP_LOAD,   10'd10,   32'h0,         32'h8000_0000);
    // positive and negative saturation
    send_command(rwu_pkg::OP_UPDATE, 10'd0,    32'h1,         32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd1023, 32'h8000_0000, 32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd9,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_command(rwu_pkg::OP_UPDATE, 10'd10,   32'hFFFF_FFFF, 32'h0);
    // no previous sign, then agreement, reversal and a zero gradient
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'h7FFF_FFFF, 32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'h1,         32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'hFFFF_FFFF, 32'h0);
    idle_gap(3);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'h0,         32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'hFFFF_FFFB, 32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'hFFFF_FFFD, 32'h0);
    send_command(rwu_pkg::OP_HOLD,   10'd5,    32'h1234_5678, 32'h0);
    send_command(rwu_pkg::OP_ZERO,   10'd5,    32'h0,         32'hFFFF_FFFF);
    send_command(rwu_pkg::OP_HOLD,   10'd0,    32'h0,         32'h0);
    send_command(rwu_pkg::OP_UPDATE, 10'd5,    32'h8000_0000, 32'h0);
    send_command(rwu_pkg::OP_ZERO,   10'd1023, 32'h0,         32'h0);
    send_command(rwu_pkg::OP_HOLD,   10'd1023, 32'h0,         32'h0);

    // random commands under each register setting
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      apply_setting(phase);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          idle_gap(($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_random_command();
      end
    end

    wait_drained();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
